### rtl/hsvle_pkg.sv
// Shared types and constants for the HSV pixel to LED SPI encoder.
`timescale 1ns / 1ps

package hsvle_pkg;

  // One converted pixel, as the back end consumes it
  typedef struct packed {
    logic [7:0] g;
    logic [7:0] r;
    logic [7:0] b;
  } hsvle_rgb_t;

  // SPI bytes per pixel: three colors, four bit pairs each
  localparam int unsigned BytesPerPixel = 12;
  localparam logic [3:0]  LastBeat      = 4'(BytesPerPixel - 1);

  // Pattern registers and their reset values, indexed by bit pair
  localparam int unsigned NumPatterns = 4;
  localparam logic [NumPatterns-1:0][7:0] PatternReset = {8'hEE, 8'hE8, 8'h8E, 8'h88};

endpackage

### rtl/hsvle_front.sv
// Front end: three-stage HSV to RGB conversion pipeline.
`timescale 1ns / 1ps

module hsvle_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            hue_i,
  input  logic [7:0]            sat_i,
  input  logic [7:0]            bright_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output hsvle_pkg::hsvle_rgb_t out_rgb_o
);

  localparam logic [1:0] SectRedGreen  = 2'd0;
  localparam logic [1:0] SectGreenBlue = 2'd1;
  localparam logic [1:0] SectBlueRed   = 2'd2;

  logic en1, en2, en3;

  logic       v1_q;
  logic [1:0] sector1_q;
  logic [5:0] offset1_q;
  logic [7:0] sat1_q, val1_q;

  logic       v2_q;
  logic [1:0] sector2_q;
  logic [7:0] val2_q, base2_q, rise2_q, fall2_q;

  logic       v3_q;
  logic [1:0] sector3_q;
  logic [7:0] base3_q, rise3_q, fall3_q;

  logic [15:0] hue_x192;
  logic [13:0] rise_prod;
  logic [7:0]  rise_d;
  logic [15:0] base_scaled, rise_scaled, fall_scaled;

  // stall propagates back from the queue
  assign en3        = !v3_q || out_ready_i;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  // hue * 192 as two shifted terms; keep the top byte
  assign hue_x192 = {1'b0, hue_i, 7'b0} + {2'b0, hue_i, 6'b0};

  // rise = offset * sat * 4 / 256
  assign rise_prod = {8'b0, offset1_q} * {6'b0, sat1_q};
  assign rise_d    = rise_prod[13:6];

  // brightness scaling
  assign base_scaled = {8'b0, base2_q} * {8'b0, val2_q};
  assign rise_scaled = {8'b0, rise2_q} * {8'b0, val2_q};
  assign fall_scaled = {8'b0, fall2_q} * {8'b0, val2_q};

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // payload stages
  always_ff @(posedge clk_i) begin
    if (en1) begin
      sector1_q <= hue_x192[15:14];
      offset1_q <= hue_x192[13:8];
      sat1_q    <= sat_i;
      val1_q    <= bright_i;
    end
    if (en2) begin
      sector2_q <= sector1_q;
      val2_q    <= val1_q;
      base2_q   <= ~sat1_q;
      rise2_q   <= rise_d;
      fall2_q   <= sat1_q - rise_d;
    end
    if (en3) begin
      sector3_q <= sector2_q;
      base3_q   <= base_scaled[15:8];
      rise3_q   <= rise_scaled[15:8];
      fall3_q   <= fall_scaled[15:8];
    end
  end

  // color assembly per sector
  always_comb begin
    out_rgb_o.r = base3_q;
    out_rgb_o.g = base3_q;
    out_rgb_o.b = base3_q;
    case (sector3_q)
      SectRedGreen: begin
        out_rgb_o.r = base3_q + fall3_q;
        out_rgb_o.g = base3_q + rise3_q;
      end
      SectGreenBlue: begin
        out_rgb_o.g = base3_q + fall3_q;
        out_rgb_o.b = base3_q + rise3_q;
      end
      SectBlueRed: begin
        out_rgb_o.r = base3_q + rise3_q;
        out_rgb_o.b = base3_q + fall3_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o = v3_q;

endmodule

### rtl/hsvle_fifo.sv
// Short queue of converted pixels between front and back ends.
`timescale 1ns / 1ps

module hsvle_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_valid_i,
  output logic                  wr_ready_o,
  input  hsvle_pkg::hsvle_rgb_t wr_data_i,
  output logic                  rd_valid_o,
  input  logic                  rd_ready_i,
  output hsvle_pkg::hsvle_rgb_t rd_data_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  hsvle_pkg::hsvle_rgb_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic push, pop;

  assign wr_ready_o = (count_q != CntFull);
  assign rd_valid_o = (count_q != '0);
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem_q[rd_ptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      if (push && !pop)      count_q <= count_q + 1'b1;
      else if (pop && !push) count_q <= count_q - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= wr_data_i;
  end

endmodule

### rtl/hsvle_back.sv
// Back end: pattern registers and serializer to twelve SPI bytes per pixel.
`timescale 1ns / 1ps

module hsvle_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [7:0]            cfg_data_i,
  input  logic                  rd_valid_i,
  output logic                  rd_ready_o,
  input  hsvle_pkg::hsvle_rgb_t rd_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            out_byte_o,
  output logic                  out_last_o
);

  logic [7:0] pat_q [hsvle_pkg::NumPatterns];
  logic [3:0] cnt_q;
  logic       ov_q;
  logic [7:0] byte_q;
  logic       last_q;

  logic       out_en, fire, at_last;
  logic [7:0] colour;
  logic [1:0] pair;

  assign cfg_ready_o = 1'b1;
  assign out_en      = !ov_q || out_ready_i;
  assign fire        = out_en && rd_valid_i;
  assign at_last     = (cnt_q == hsvle_pkg::LastBeat);
  assign rd_ready_o  = fire && at_last;

  // color order G, R, B; pairs MSB first
  always_comb begin
    case (cnt_q[3:2])
      2'd0:    colour = rd_data_i.g;
      2'd1:    colour = rd_data_i.r;
      default: colour = rd_data_i.b;
    endcase
    case (cnt_q[1:0])
      2'd0:    pair = colour[7:6];
      2'd1:    pair = colour[5:4];
      2'd2:    pair = colour[3:2];
      default: pair = colour[1:0];
    endcase
  end

  // pattern registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < hsvle_pkg::NumPatterns; i++) begin
        pat_q[i] <= hsvle_pkg::PatternReset[i];
      end
    end else if (cfg_valid_i) begin
      pat_q[cfg_index_i] <= cfg_data_i;
    end
  end

  // beat counter and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ov_q  <= 1'b0;
    end else if (fire) begin
      cnt_q <= at_last ? '0 : cnt_q + 1'b1;
      ov_q  <= 1'b1;
    end else if (out_en) begin
      ov_q  <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      byte_q <= pat_q[pair];
      last_q <= at_last;
    end
  end

  assign out_valid_o = ov_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;

endmodule

### rtl/hsv_pixel_to_led_spi_encoder_unit.sv
// Path: a pixel beat passes the three conversion stages, the queue and the back end's
//   output register before its first SPI byte is valid.
// Output: one SPI byte per cycle while the sink is ready, twelve bytes per pixel;
//   the conversion pipeline and queue absorb up to 3 + FifoDepth pixels ahead.
// Reset: asynchronous active low; clears all valid state and loads the
//   pattern registers with 0x88, 0x8E, 0xE8, 0xEE.
`timescale 1ns / 1ps

module hsv_pixel_to_led_spi_encoder_unit #(
  parameter int unsigned FifoDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // pixel in
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // [7:0] hue, [15:8] saturation, [23:16] brightness
  // SPI bytes out
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] spi_byte
  output logic        m_axis_tlast_o,   // last_byte
  // pattern register writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  hsvle_pkg::hsvle_rgb_t fr_rgb, q_rgb;
  logic fr_valid, fr_ready, q_valid, q_ready;

  hsvle_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .hue_i       (s_axis_tdata_i[7:0]),
    .sat_i       (s_axis_tdata_i[15:8]),
    .bright_i    (s_axis_tdata_i[23:16]),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .out_rgb_o   (fr_rgb)
  );

  hsvle_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fr_valid),
    .wr_ready_o (fr_ready),
    .wr_data_i  (fr_rgb),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_data_o  (q_rgb)
  );

  hsvle_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .rd_valid_i  (q_valid),
    .rd_ready_o  (q_ready),
    .rd_data_i   (q_rgb),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_byte_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

### rtl/hsvle_checker.sv
// Port-level checks for the encoder, bound to the top level.
`timescale 1ns / 1ps

module hsvle_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [7:0]  m_axis_tdata_o,
  input logic        m_axis_tlast_o,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o
);

  logic [3:0] beat_q;
  logic [7:0] pend_q;
  logic in_beat, out_beat, out_end;

  assign in_beat  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_beat = m_axis_tvalid_o && m_axis_tready_i;
  assign out_end  = out_beat && m_axis_tlast_o;

  // output beat position within a pixel, and pixels not yet fully sent
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q <= '0;
      pend_q <= '0;
    end else begin
      if (out_beat) beat_q <= (beat_q == hsvle_pkg::LastBeat) ? '0 : beat_q + 1'b1;
      if (in_beat && !out_end)      pend_q <= pend_q + 1'b1;
      else if (out_end && !in_beat) pend_q <= pend_q - 1'b1;
    end
  end

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output beat changed while stalled");

  // tlast exactly on the twelfth byte
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tlast_o == (beat_q == hsvle_pkg::LastBeat)))
    else $error("tlast not on twelfth byte of pixel");

  // no output without an accepted pixel behind it
  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (pend_q != '0))
    else $error("output beat without pending pixel");

  // configuration channel never stalls
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write stalled");

endmodule

bind hsv_pixel_to_led_spi_encoder_unit hsvle_checker u_hsvle_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .cfg_valid_i     (cfg_valid_i),
  .cfg_ready_o     (cfg_ready_o)
);
